@@ hdl/bos_pkg.sv @@
`default_nettype none

package bos_pkg;

    // Default number of stack entries
    localparam int unsigned STACK_DEPTH_DEF = 32;
    // Largest number of words one print-all emits
    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned DATA_W = 32;

    // Opcodes carried in func; code 7 has no meaning and acts as nop
    typedef enum logic [2:0] {
        OP_PUSH      = 3'd0,
        OP_PRINT_ALL = 3'd1,
        OP_PRINT_TOP = 3'd2,
        OP_POP       = 3'd3,
        OP_SWAP      = 3'd4,
        OP_ADD       = 3'd5,
        OP_NOP       = 3'd6
    } opcode_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SHORT = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // What every cell of the chain does in one cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_SWAP,
        CELL_ADD,
        CELL_ROT
    } cell_op_t;

    // Control word broadcast along the chain
    typedef struct packed {
        cell_op_t op;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/bos_ifs.sv @@
`default_nettype none

// Request channel: one opcode word
interface bos_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

// Response channel: one result word
interface bos_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic               has_value;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, output read_value, output has_value,
                    output status, output last, input ready);
    modport sink   (input valid, input read_value, input has_value,
                    input status, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/bos_cell.sv @@
`default_nettype none

// One stack slot; INDEX 0 is the top of the stack
module bos_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CW    = 6
) (
    input  wire                              clk,
    input  wire bos_pkg::cell_ctl_t          ctl,
    input  wire [CW-1:0]                     count,
    input  wire [bos_pkg::DATA_W-1:0]        upper,
    input  wire [bos_pkg::DATA_W-1:0]        lower,
    input  wire [bos_pkg::DATA_W-1:0]        top,
    output logic [bos_pkg::DATA_W-1:0]       value
);

    logic [bos_pkg::DATA_W-1:0] value_reg;
    logic [bos_pkg::DATA_W-1:0] value_next;
    logic                       is_bottom;

    // This cell holds the deepest live entry
    assign is_bottom = (count == CW'(INDEX + 1));

    // Neighbor selection
    always_comb
    begin
        value_next = value_reg;
        case (ctl.op)
            bos_pkg::CELL_HOLD: value_next = value_reg;
            bos_pkg::CELL_PUSH: value_next = upper;
            bos_pkg::CELL_POP:  value_next = lower;
            bos_pkg::CELL_SWAP:
            begin
                if (INDEX == 0)
                    value_next = lower;
                else if (INDEX == 1)
                    value_next = upper;
            end
            bos_pkg::CELL_ADD:
            begin
                if (INDEX == 0)
                    value_next = value_reg + lower; // wraps mod 2^32
                else
                    value_next = lower;
            end
            bos_pkg::CELL_ROT:
            begin
                if (is_bottom)
                    value_next = top;
                else
                    value_next = lower;
            end
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

@@ hdl/bytecode_operand_stack_top.sv @@
// Operand stack of signed 32-bit words, one opcode word per request.
// req (sink): func and push_value, taken when valid and ready are high.
// rsp (source): read_value, has_value, status and last per result word.
// Every opcode but print-all gives one result word, registered in the cycle
// after the request is taken; a new request is taken every cycle while
// rsp is not stalled and no print-all is running. Print-all with N entries
// first starts, then rotates the cell chain once per cycle while rsp is
// not stalled, the top cell giving one word per rotation from top to
// bottom; the last word has last set. Past MAX_RESULTS words the chain
// keeps rotating without output so that the stack order comes back. An
// empty stack gives one word, no value. A failed opcode leaves the stack
// as it was and reports a status. Reset clears the entry count and output
// valid; slot contents are kept but are never read before written.
// While rsp stalls, the result word holds and req is not taken; print-all
// pauses its rotation until the word is taken, but not past MAX_RESULTS.
`default_nettype none

module bytecode_operand_stack_top #(
    parameter int unsigned STACK_DEPTH = bos_pkg::STACK_DEPTH_DEF
) (
    input  wire   clk,
    input  wire   rst_n,
    bos_req_if.sink   req,
    bos_rsp_if.source rsp
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned DW = bos_pkg::DATA_W;

    logic [DW-1:0]      vals [STACK_DEPTH];
    bos_pkg::cell_ctl_t ctl;

    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               out_valid_reg, out_valid_next;
    logic [DW-1:0]      read_value_reg, read_value_next;
    logic               has_value_reg, has_value_next;
    bos_pkg::status_t   status_reg, status_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic               in_fire;
    logic               emit_now;
    logic [CW-1:0]      step_inc;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !busy_reg && out_free;
    assign in_fire   = req.valid && req.ready;
    assign step_inc  = CW'(step_reg + 1'b1);
    assign emit_now  = (32'(step_reg) < 32'(bos_pkg::MAX_RESULTS));

    // Chain of cells
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [DW-1:0] upper_w;
        logic [DW-1:0] lower_w;
        if (i == 0)
        begin : g_top
            assign upper_w = req.push_value;
        end
        else
        begin : g_mid
            assign upper_w = vals[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_bot
            assign lower_w = vals[i];
        end
        else
        begin : g_lowr
            assign lower_w = vals[i+1];
        end
        bos_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .count (count_reg),
            .upper (upper_w),
            .lower (lower_w),
            .top   (vals[0]),
            .value (vals[i])
        );
    end

    // Opcode decode and print-all sequencing
    always_comb
    begin
        ctl.op          = bos_pkg::CELL_HOLD;
        count_next      = count_reg;
        step_next       = step_reg;
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        read_value_next = read_value_reg;
        has_value_next  = has_value_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        if (busy_reg)
        begin
            if (!emit_now || out_free)
            begin
                ctl.op    = bos_pkg::CELL_ROT;
                step_next = step_inc;
                if (step_inc == count_reg)
                    busy_next = 1'b0;
                if (emit_now)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = vals[0];
                    has_value_next  = 1'b1;
                    status_next     = bos_pkg::ST_OK;
                    last_next       = (step_inc == count_reg) ||
                                      (32'(step_inc) == 32'(bos_pkg::MAX_RESULTS));
                end
            end
        end
        else if (in_fire)
        begin
            out_valid_next  = 1'b1;
            read_value_next = '0;
            has_value_next  = 1'b0;
            status_next     = bos_pkg::ST_OK;
            last_next       = 1'b1;
            case (bos_pkg::opcode_t'(req.func))
                bos_pkg::OP_PUSH:
                begin
                    if (count_reg == CW'(STACK_DEPTH))
                        status_next = bos_pkg::ST_FULL;
                    else
                    begin
                        ctl.op     = bos_pkg::CELL_PUSH;
                        count_next = CW'(count_reg + 1'b1);
                    end
                end
                bos_pkg::OP_PRINT_ALL:
                begin
                    if (count_reg != '0)
                    begin
                        out_valid_next = 1'b0;
                        busy_next      = 1'b1;
                        step_next      = '0;
                    end
                end
                bos_pkg::OP_PRINT_TOP:
                begin
                    if (count_reg == '0)
                        status_next = bos_pkg::ST_EMPTY;
                    else
                    begin
                        read_value_next = vals[0];
                        has_value_next  = 1'b1;
                    end
                end
                bos_pkg::OP_POP:
                begin
                    if (count_reg == '0)
                        status_next = bos_pkg::ST_EMPTY;
                    else
                    begin
                        ctl.op     = bos_pkg::CELL_POP;
                        count_next = CW'(count_reg - 1'b1);
                    end
                end
                bos_pkg::OP_SWAP:
                begin
                    if (count_reg < CW'(2))
                        status_next = bos_pkg::ST_SHORT;
                    else
                        ctl.op = bos_pkg::CELL_SWAP;
                end
                bos_pkg::OP_ADD:
                begin
                    if (count_reg < CW'(2))
                        status_next = bos_pkg::ST_SHORT;
                    else
                    begin
                        ctl.op     = bos_pkg::CELL_ADD;
                        count_next = CW'(count_reg - 1'b1);
                    end
                end
                default: ; // nop and unused code
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            step_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            step_reg      <= step_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        has_value_reg  <= has_value_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.has_value  = has_value_reg;
    assign rsp.status     = status_reg;
    assign rsp.last       = last_reg;

endmodule

`default_nettype wire

@@ sim/bytecode_operand_stack_checker.sv @@
// Watches the request and result channels, keeps a shadow copy of the
// operand stack and checks every result word against the predicted one.
module bytecode_operand_stack_checker #(
    parameter int unsigned STACK_DEPTH = bos_pkg::STACK_DEPTH_DEF
) (
    input  wire clk,
    input  wire rst_n,
    bos_req_if  req,
    bos_rsp_if  rsp,
    output int  fail_count,
    output int  outstanding
);

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               has_value;
        bos_pkg::status_t   status;
        logic               last;
    } result_word_t;

    // Shadow of the stack, slot 0 at the bottom
    logic signed [31:0] stack_shadow [STACK_DEPTH];
    int unsigned        depth_used = 0;
    result_word_t       expected_words [$];
    int                 mismatches = 0;
    int                 queued = 0;

    assign fail_count  = mismatches;
    assign outstanding = queued;

    // Single status word, no value carried
    function automatic result_word_t status_word(input bos_pkg::status_t st);
        result_word_t w;
        w.read_value = '0;
        w.has_value  = 1'b0;
        w.status     = st;
        w.last       = 1'b1;
        return w;
    endfunction

    // Update the shadow stack for one opcode word, queue its result words
    task automatic apply_opcode(input logic [2:0] code, input logic signed [31:0] value);
        int unsigned        emit;
        logic signed [31:0] hold;
        result_word_t       w;
        case (code)
            bos_pkg::OP_PUSH:
            begin
                if (depth_used >= STACK_DEPTH)
                    expected_words.push_back(status_word(bos_pkg::ST_FULL));
                else
                begin
                    stack_shadow[depth_used] = value;
                    depth_used++;
                    expected_words.push_back(status_word(bos_pkg::ST_OK));
                end
            end
            bos_pkg::OP_PRINT_ALL:
            begin
                if (depth_used == 0)
                    expected_words.push_back(status_word(bos_pkg::ST_OK));
                else
                begin
                    emit = (depth_used > bos_pkg::MAX_RESULTS) ?
                           bos_pkg::MAX_RESULTS : depth_used;
                    for (int unsigned i = 0; i < emit; i++)
                    begin
                        w.read_value = stack_shadow[depth_used - 1 - i];
                        w.has_value  = 1'b1;
                        w.status     = bos_pkg::ST_OK;
                        w.last       = (i + 1 == emit);
                        expected_words.push_back(w);
                    end
                end
            end
            bos_pkg::OP_PRINT_TOP:
            begin
                if (depth_used == 0)
                    expected_words.push_back(status_word(bos_pkg::ST_EMPTY));
                else
                begin
                    w = status_word(bos_pkg::ST_OK);
                    w.read_value = stack_shadow[depth_used - 1];
                    w.has_value  = 1'b1;
                    expected_words.push_back(w);
                end
            end
            bos_pkg::OP_POP:
            begin
                if (depth_used == 0)
                    expected_words.push_back(status_word(bos_pkg::ST_EMPTY));
                else
                begin
                    depth_used--;
                    expected_words.push_back(status_word(bos_pkg::ST_OK));
                end
            end
            bos_pkg::OP_SWAP:
            begin
                if (depth_used < 2)
                    expected_words.push_back(status_word(bos_pkg::ST_SHORT));
                else
                begin
                    hold = stack_shadow[depth_used - 1];
                    stack_shadow[depth_used - 1] = stack_shadow[depth_used - 2];
                    stack_shadow[depth_used - 2] = hold;
                    expected_words.push_back(status_word(bos_pkg::ST_OK));
                end
            end
            bos_pkg::OP_ADD:
            begin
                if (depth_used < 2)
                    expected_words.push_back(status_word(bos_pkg::ST_SHORT));
                else
                begin
                    // 32-bit sum wraps on its own
                    stack_shadow[depth_used - 2] =
                        stack_shadow[depth_used - 2] + stack_shadow[depth_used - 1];
                    depth_used--;
                    expected_words.push_back(status_word(bos_pkg::ST_OK));
                end
            end
            // nop and the unused code
            default:
                expected_words.push_back(status_word(bos_pkg::ST_OK));
        endcase
    endtask

    task automatic report_mismatch(input string what, input result_word_t exp_w,
                                   input result_word_t got_w);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t %s: expected value %0d has %0b status %0d last %0b,",
                      " got value %0d has %0b status %0d last %0b"},
                     $time, what, exp_w.read_value, exp_w.has_value, exp_w.status,
                     exp_w.last, got_w.read_value, got_w.has_value, got_w.status,
                     got_w.last);
    endtask

    // Requests first, so a word taken this edge is already predicted
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t got_w;
        result_word_t exp_w;
        if (!rst_n)
        begin
            depth_used = 0;
            expected_words.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                apply_opcode(req.func, req.push_value);
            if (rsp.valid && rsp.ready)
            begin
                got_w.read_value = rsp.read_value;
                got_w.has_value  = rsp.has_value;
                got_w.status     = bos_pkg::status_t'(rsp.status);
                got_w.last       = rsp.last;
                if (expected_words.size() == 0)
                    report_mismatch("unexpected result word", '0, got_w);
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (got_w.read_value !== exp_w.read_value
                        || got_w.has_value !== exp_w.has_value
                        || got_w.status !== exp_w.status
                        || got_w.last !== exp_w.last)
                        report_mismatch("result word mismatch", exp_w, got_w);
                end
            end
        end
        queued = expected_words.size();
    end

endmodule

@@ sim/bytecode_operand_stack_top_tb.sv @@
// Drives opcode words into the operand stack with random gaps and stalls;
// the checker beside the block does the prediction and comparison.
module bytecode_operand_stack_top_tb;

    // func code with no meaning, acts as nop
    localparam logic [2:0]  FUNC_UNUSED  = 3'd7;
    localparam int unsigned DEPTH        = bos_pkg::STACK_DEPTH_DEF;
    localparam int          RANDOM_WORDS = 128;

    logic clk;
    logic rst_n;
    bit   steady = 1'b0;
    int   fail_count;
    int   outstanding;
    int   words_sent = 0;

    bos_req_if req_ch ();
    bos_rsp_if rsp_ch ();

    bytecode_operand_stack_top #(
        .STACK_DEPTH(DEPTH)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    bytecode_operand_stack_checker #(
        .STACK_DEPTH(DEPTH)
    ) stack_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random stalls except during the steady stretch
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    // Hard stop in case the block hangs
    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // One opcode word, held until taken; returns on the next falling edge
    task automatic send_word(input logic [2:0] code, input logic signed [31:0] value);
        while (!steady && $urandom_range(99) < 31)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= code;
        req_ch.push_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // Hold off until every predicted word has come back
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    // Extremes, small values near zero, or anything
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(5))
            0: v = 32'sh7fff_ffff;
            1: v = 32'sh8000_0000;
            2: v = $signed(32'($urandom_range(16))) - 8;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial
    begin
        int          fills;
        int          burst;
        int          random_end;
        logic [2:0]  code;
        fills = 0;
        rst_n = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = bos_pkg::OP_NOP;
        req_ch.push_value = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-stack errors, short-stack errors, wraparound
        send_word(bos_pkg::OP_PRINT_ALL, 0);
        send_word(bos_pkg::OP_PRINT_TOP, 0);
        send_word(bos_pkg::OP_POP, 0);
        send_word(bos_pkg::OP_SWAP, 0);
        send_word(bos_pkg::OP_ADD, 0);
        send_word(bos_pkg::OP_PUSH, 32'sh7fff_ffff);
        send_word(bos_pkg::OP_SWAP, 0);
        send_word(bos_pkg::OP_ADD, 0);
        send_word(bos_pkg::OP_PUSH, 32'sh7fff_ffff);
        send_word(bos_pkg::OP_ADD, 0);
        send_word(bos_pkg::OP_PRINT_TOP, 0);
        send_word(bos_pkg::OP_PUSH, 32'sh8000_0000);
        send_word(bos_pkg::OP_PUSH, 32'sh8000_0000);
        send_word(bos_pkg::OP_ADD, 0);
        send_word(bos_pkg::OP_PUSH, -1);
        send_word(bos_pkg::OP_PUSH, 1);
        send_word(bos_pkg::OP_SWAP, 0);
        send_word(bos_pkg::OP_PRINT_ALL, 0);
        send_word(bos_pkg::OP_NOP, 32'sh5a5a_a5a5);
        send_word(FUNC_UNUSED, -1);
        send_word(bos_pkg::OP_POP, 0);
        send_word(bos_pkg::OP_PRINT_ALL, 0);
        hold_until_drained();

        // Random: single random opcodes, push bursts followed by stack work, pop bursts, some fills
        random_end = words_sent + RANDOM_WORDS;
        while (words_sent < random_end)
        begin
            steady = (words_sent >= random_end - 110) && (words_sent < random_end - 70);
            case ($urandom_range(9))
                0:
                begin
                    // push past full, dump it all, then let it drain
                    if (fills < 2)
                    begin
                        fills++;
                        repeat (DEPTH + 2) send_word(bos_pkg::OP_PUSH, pick_value());
                        send_word(bos_pkg::OP_PRINT_ALL, pick_value());
                        hold_until_drained();
                    end
                end
                1, 2, 3:
                begin
                    burst = $urandom_range(6, 1);
                    repeat (burst) send_word(bos_pkg::OP_PUSH, pick_value());
                    code = 3'($urandom_range(bos_pkg::OP_ADD, bos_pkg::OP_PRINT_ALL));
                    send_word(code, pick_value());
                end
                4:
                begin
                    burst = $urandom_range(10, 1);
                    repeat (burst) send_word(bos_pkg::OP_POP, pick_value());
                end
                default:
                begin
                    code = 3'($urandom_range(7));
                    send_word(code, pick_value());
                end
            endcase
        end
        steady = 1'b0;

        req_ch.valid <= 1'b0;
        @(negedge clk);
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
